[hdl/kmc_pkg.sv]
// shared types and constants of the probe k-mer occurrence counter
package kmc_pkg;

  localparam int CFG_W = 6;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int ENTRY_W = 12;
  localparam int COUNT_W = 32;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_SEQ   = 2'd1,
    OP_EOS   = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_BAD_LEN = 2'd2,
    STS_BAD_IDX = 2'd3
  } status_t;

  typedef enum logic {
    REG_LEN_A = 1'b0,
    REG_LEN_B = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_NEXT,
    ST_INSERT,
    ST_RD_ISSUE,
    ST_RD_CNT,
    ST_DONE
  } state_t;

endpackage

[hdl/kmc_ram.sv]
// generic single-port-write ram with registered read
module kmc_ram #(
  parameter int W = 32,
  parameter int D = 4096,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/probe_kmer_occurrence_counter.sv]
// top level of the probe k-mer occurrence counter
//
// Input stream (s_axis): tuser carries the opcode, tlast marks the final
// byte of a probe, tdata carries the character and the entry index. Every
// input transfer yields exactly one result transfer on m_axis.
// Probe bytes collect in a staging register; the final byte searches the
// key memory and inserts the probe if it is new. Sequence bytes shift into
// a window of MAX_LEN bytes; the trailing len_a (and len_b) bytes are
// searched and a matching entry's count is incremented, saturating.
// The search walks the loaded entries through the key memory port, reading
// and then comparing one entry at a time; a sequence byte does up to two
// such searches. A non-final probe byte, a newline, end of sequence and a
// read do no search.
// One item is in work at a time; a new item is taken once the previous
// result sits in the output register, which holds while m_axis_tready is
// low, so a stalled receiver blocks at most the following result.
// Reset empties the table, staging and window and sets both lengths to 20;
// no clearing pass is needed. cfg_we writes len_a (index 0) or len_b
// (index 1); the user must do so only while the block is idle (not enforced).
module probe_kmer_occurrence_counter
  import kmc_pkg::*;
#(
  parameter int MAX_LEN = 32,
  parameter int NUM_PROBES = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // data_byte [7:0], entry_index [19:8], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]             s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status [1:0], entry_out [13:2], duplicate [14], count [46:15],
  // hit_a [47], hit_b [48], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int BW = $clog2(MAX_LEN);
  localparam int KB = MAX_LEN * 8;
  localparam int KW = KB + LW;
  localparam int IW = $clog2(NUM_PROBES);
  localparam int CW = $clog2(NUM_PROBES + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]   len_a, len_b;
  logic [KB-1:0]      window;
  logic [LW-1:0]      wfill;
  logic [KB-1:0]      stg;
  logic [LW-1:0]      sfill;
  logic               sovf;
  logic [CW-1:0]      loaded;
  logic               mode_ins;
  logic               sel_b;
  logic [IW-1:0]      scan_idx;
  logic [IW-1:0]      rd_addr;
  logic [KB-1:0]      key;
  logic [LW-1:0]      key_len;
  logic [1:0]         r_status;
  logic [ENTRY_W-1:0] r_entry;
  logic               r_dup;
  logic [COUNT_W-1:0] r_count;
  logic               r_hit_a, r_hit_b;

  // input fields
  logic               acc;
  opcode_t            op;
  logic [7:0]         in_byte;
  logic [7:0]         seq_byte;
  logic [ENTRY_W-1:0] in_idx;
  logic               ovf_now;
  logic               rd_ok;

  // window key forming
  logic [CFG_W-1:0]   win_len6;
  logic               win_valid;
  logic [LW+2:0]      win_shift;
  logic [KB-1:0]      win_key;
  logic [KB-1:0]      stg_key;

  // memory ports
  logic               kram_we;
  logic [IW-1:0]      kram_waddr;
  logic [KW-1:0]      kram_wdata;
  logic [IW-1:0]      kram_raddr;
  logic [KW-1:0]      kram_rdata;
  logic               cram_we;
  logic [IW-1:0]      cram_waddr;
  logic [COUNT_W-1:0] cram_wdata;
  logic [IW-1:0]      cram_raddr;
  logic [COUNT_W-1:0] cram_rdata;

  logic               key_match;
  logic               scan_last;
  logic               table_full;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign op = opcode_t'(s_axis_tuser);
  assign in_byte = s_axis_tdata[7:0];
  assign in_idx = s_axis_tdata[19:8];
  assign ovf_now = sovf || (int'(sfill) >= MAX_LEN);
  assign rd_ok = (int'(in_idx) < int'(loaded));

  // upper-case folding of sequence letters
  assign seq_byte = (in_byte != CH_DASH && in_byte >= 8'h61 && in_byte <= 8'h7A) ?
                    (in_byte - 8'h20) : in_byte;

  // trailing window bytes, zero above the window length
  assign win_len6 = sel_b ? len_b : len_a;
  assign win_valid = (win_len6 != '0) && (int'(win_len6) <= MAX_LEN) &&
                     (int'(wfill) >= int'(win_len6));
  assign win_shift = {(LW'(MAX_LEN) - LW'(win_len6)), 3'b000};
  assign win_key = window >> win_shift;

  // staged probe bytes masked to the probe length
  always_comb begin
    for (int k = 0; k < MAX_LEN; k++) begin
      stg_key[8*k +: 8] = (k < int'(key_len)) ? stg[8*k +: 8] : 8'h00;
    end
  end

  assign key_match = (kram_rdata == {key_len, key});
  assign scan_last = ((CW'(scan_idx) + CW'(1)) == loaded);
  assign table_full = (int'(loaded) >= NUM_PROBES);

  // key memory: length and packed key per entry
  kmc_ram #(.W(KW), .D(NUM_PROBES)) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (kram_waddr),
    .wdata (kram_wdata),
    .raddr (kram_raddr),
    .rdata (kram_rdata)
  );

  // hit count memory
  kmc_ram #(.W(COUNT_W), .D(NUM_PROBES)) u_count_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .raddr (cram_raddr),
    .rdata (cram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_PROBE: state_next = (s_axis_tlast && !ovf_now) ? ST_PREP : ST_DONE;
            OP_SEQ:   state_next = (in_byte != CH_NEWLINE) ? ST_PREP : ST_DONE;
            OP_EOS:   state_next = ST_DONE;
            OP_READ:  state_next = rd_ok ? ST_RD_ISSUE : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_PREP: begin
        if (mode_ins) begin
          state_next = (loaded != '0) ? ST_SCAN_RD : ST_INSERT;
        end else if (win_valid && loaded != '0) begin
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_SCAN_RD:  state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (key_match) begin
          state_next = mode_ins ? ST_DONE : ST_CNT_RD;
        end else if (scan_last) begin
          state_next = mode_ins ? ST_INSERT : ST_NEXT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_CNT_RD:   state_next = ST_CNT_WR;
      ST_CNT_WR:   state_next = ST_NEXT;
      ST_NEXT:     state_next = (!sel_b && len_b != len_a) ? ST_PREP : ST_DONE;
      ST_INSERT:   state_next = ST_DONE;
      ST_RD_ISSUE: state_next = ST_RD_CNT;
      ST_RD_CNT:   state_next = ST_DONE;
      ST_DONE:     state_next = (!m_axis_tvalid || m_axis_tready) ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    kram_we    = 1'b0;
    kram_waddr = IW'(loaded);
    kram_wdata = {key_len, key};
    kram_raddr = scan_idx;
    cram_we    = 1'b0;
    cram_waddr = scan_idx;
    cram_wdata = (cram_rdata == COUNT_MAX) ? cram_rdata : (cram_rdata + COUNT_W'(1));
    cram_raddr = scan_idx;
    unique case (state)
      ST_INSERT: begin
        kram_we    = !table_full;
        cram_we    = !table_full;
        cram_waddr = IW'(loaded);
        cram_wdata = '0;
      end
      ST_CNT_WR:   cram_we = 1'b1;
      ST_RD_ISSUE: cram_raddr = rd_addr;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= CFG_W'(20);
      len_b <= CFG_W'(20);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_LEN_A: len_a <= cfg_data;
        REG_LEN_B: len_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: window, staging, table fill, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      wfill         <= '0;
      sfill         <= '0;
      sovf          <= 1'b0;
      loaded        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        unique case (op)
          OP_PROBE: begin
            if (s_axis_tlast) begin
              sfill <= '0;
              sovf  <= 1'b0;
            end else if (ovf_now) begin
              sovf <= 1'b1;
            end else begin
              sfill <= sfill + LW'(1);
            end
          end
          OP_SEQ: begin
            if (in_byte != CH_NEWLINE) begin
              window <= {seq_byte, window[KB-1:8]};
              if (int'(wfill) < MAX_LEN) begin
                wfill <= wfill + LW'(1);
              end
            end
          end
          OP_EOS: begin
            window <= '0;
            wfill  <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_INSERT && !table_full) begin
        loaded <= loaded + CW'(1);
      end
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath: staging bytes, search key, result fields
  always_ff @(posedge clk) begin
    if (acc) begin
      r_status <= (op == OP_PROBE && s_axis_tlast && ovf_now) ? STS_BAD_LEN :
                  (op == OP_READ && !rd_ok) ? STS_BAD_IDX : STS_OK;
      r_entry  <= '0;
      r_dup    <= 1'b0;
      r_count  <= '0;
      r_hit_a  <= 1'b0;
      r_hit_b  <= 1'b0;
      mode_ins <= (op == OP_PROBE);
      sel_b    <= 1'b0;
      rd_addr  <= IW'(in_idx);
      if (op == OP_PROBE) begin
        if (!ovf_now) begin
          stg[{BW'(sfill), 3'b000} +: 8] <= in_byte;
        end
        key_len <= sfill + LW'(1);
      end
    end
    unique case (state)
      ST_PREP: begin
        scan_idx <= '0;
        if (mode_ins) begin
          key <= stg_key;
        end else begin
          key     <= win_key;
          key_len <= LW'(win_len6);
        end
      end
      ST_SCAN_CMP: begin
        if (key_match) begin
          if (mode_ins) begin
            r_entry <= ENTRY_W'(scan_idx);
            r_dup   <= 1'b1;
          end
        end else if (!scan_last) begin
          scan_idx <= scan_idx + IW'(1);
        end
      end
      ST_CNT_WR: begin
        if (sel_b) begin
          r_hit_b <= 1'b1;
        end else begin
          r_hit_a <= 1'b1;
        end
      end
      ST_NEXT:   sel_b <= 1'b1;
      ST_INSERT: begin
        if (table_full) begin
          r_status <= STS_FULL;
        end else begin
          r_entry <= ENTRY_W'(loaded);
        end
      end
      ST_RD_CNT: r_count <= cram_rdata;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= OUT_TDATA_W'({r_hit_b, r_hit_a, r_count, r_dup, r_entry, r_status});
        end
      end
      default: ;
    endcase
  end

  // table fill never passes the table size
  assert property (@(posedge clk) disable iff (rst) int'(loaded) <= NUM_PROBES)
    else $error("entry count beyond table size");

  // scan index stays inside the loaded entries
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CMP) |-> (CW'(scan_idx) < loaded))
    else $error("scan beyond loaded entries");

  // a new result only comes from the result stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result raised outside result stage");

  // the key memory is written only by an insert that fits
  assert property (@(posedge clk) disable iff (rst)
    kram_we |-> (state == ST_INSERT && !table_full))
    else $error("stray key memory write");

endmodule
